// File: src/heap_sort_engine_assert.svh
// Assertion macros shared by the heap sort engine.
`ifndef HEAP_SORT_ENGINE_ASSERT_SVH
`define HEAP_SORT_ENGINE_ASSERT_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define HSE_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("heap_sort_engine: assertion failed");

// Next-cycle implication, sampled on clock, off during reset.
`define HSE_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("heap_sort_engine: assertion failed");

`endif

// File: src/hse_pkg.sv
// Shared constants, command codes and microcode types of the heap sort engine.
package hse_pkg;

   localparam int DEPTH       = 256;
   localparam int VALUE_WIDTH = 32;
   localparam int ADDR_W      = $clog2(DEPTH);
   localparam int CNT_W       = $clog2(DEPTH + 1);

   localparam int CMD_W       = 2;
   localparam int INDEX_W     = 8;
   localparam int IN_VALUE_W  = 32;
   localparam int COUNT_W     = 9;
   localparam int OUT_VALUE_W = 32;
   localparam int REQ_DATA_W  = INDEX_W + IN_VALUE_W;

   localparam logic [CMD_W-1:0] CMD_LOAD = CMD_W'(0);
   localparam logic [CMD_W-1:0] CMD_SORT = CMD_W'(1);
   localparam logic [CMD_W-1:0] CMD_READ = CMD_W'(2);

   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] ST_IDLE      = STEP_W'(0);
   localparam logic [STEP_W-1:0] ST_DISPATCH  = STEP_W'(1);
   localparam logic [STEP_W-1:0] ST_RD_IDX    = STEP_W'(2);
   localparam logic [STEP_W-1:0] ST_RESP_RD   = STEP_W'(3);
   localparam logic [STEP_W-1:0] ST_RESP_LD   = STEP_W'(4);
   localparam logic [STEP_W-1:0] ST_SORT_INIT = STEP_W'(5);
   localparam logic [STEP_W-1:0] ST_BUILD     = STEP_W'(6);
   localparam logic [STEP_W-1:0] ST_LOAD_CUR  = STEP_W'(7);
   localparam logic [STEP_W-1:0] ST_SIFT_RD   = STEP_W'(8);
   localparam logic [STEP_W-1:0] ST_SIFT_CMP  = STEP_W'(9);
   localparam logic [STEP_W-1:0] ST_SIFT_END  = STEP_W'(10);
   localparam logic [STEP_W-1:0] ST_EXTRACT   = STEP_W'(11);
   localparam logic [STEP_W-1:0] ST_EXT_SWAP  = STEP_W'(12);
   localparam logic [STEP_W-1:0] ST_DONE      = STEP_W'(13);

   typedef enum logic [3:0] {
      OP_NOP,
      OP_ACCEPT,
      OP_RD_IDX,
      OP_RESP_RD,
      OP_RESP_LD,
      OP_SORT_INIT,
      OP_BUILD,
      OP_LOAD_CUR,
      OP_SIFT_RD,
      OP_SIFT_CMP,
      OP_EXTRACT,
      OP_EXT_SWAP,
      OP_RESP_SORT
   } op_type;

   typedef enum logic [2:0] {
      C_NEVER,
      C_ALWAYS,
      C_NO_ITEM,
      C_CMD_SORT,
      C_CMD_LOAD,
      C_BP_ZERO,
      C_BP_NONZERO,
      C_HS_LE1
   } cond_type;

   typedef struct packed {
      op_type            op;
      cond_type          cond;
      logic [STEP_W-1:0] target;
   } ucode_type;

   typedef struct packed {
      logic item;
      logic cmd_sort;
      logic cmd_load;
      logic bp_zero;
      logic hs_le1;
      logic sift_move;
      logic hold;
   } status_type;

endpackage

// File: src/heap_sort_engine.sv
// Heap sort engine top level: element store, datapath and stream ports.
//
// Usage: items enter on the req_ channel (tuser = command, tdata = index and
// value). A load writes value at index, a read returns the stored value, a
// sort puts the first element_count entries into ascending order in place.
// Every item gives exactly one transaction on the rsp_ channel carrying
// read_value (zero unless a read) and the sorted flag.
// element_count is written through the csr_ channel, which is always ready;
// write it only while the engine is idle. Reset sets it to 1.
// A load or read passes the dispatch, index-read and result steps; the next
// item is taken only once the sequencer is back at the idle step.
// A sort is driven by the microcode sequencer: every sift level has a step
// of two-port store reads and a step of compare and write.
// One item is worked on at a time; req_tready is high only at the idle step.
// The result register frees the input side: a new item is accepted while a
// result still waits, and the sequencer holds at its next result step while
// rsp_tready stays low. Reset clears control state and the sorted flag; the
// store content is undefined until written and needs no clearing pass.
`include "heap_sort_engine_assert.svh"

module heap_sort_engine (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [hse_pkg::REQ_DATA_W-1:0]       req_tdata,  // index, value
   input  logic [hse_pkg::CMD_W-1:0]            req_tuser,  // command
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [hse_pkg::OUT_VALUE_W-1:0]      rsp_tdata,  // read_value
   output logic                                 rsp_tuser,  // sorted
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [hse_pkg::COUNT_W-1:0]          csr_data    // element_count
);
   import hse_pkg::*;

   localparam int IDX_W = ADDR_W + 2;

   ucode_type         uword;
   status_type        status;
   logic [STEP_W-1:0] step;

   logic [VALUE_WIDTH-1:0] mem [DEPTH];
   logic [VALUE_WIDTH-1:0] rd_a_ff;
   logic [VALUE_WIDTH-1:0] rd_b_ff;
   logic [ADDR_W-1:0]      ra_a;
   logic [ADDR_W-1:0]      ra_b;
   logic                   we;
   logic [ADDR_W-1:0]      wa;
   logic [VALUE_WIDTH-1:0] wd;

   logic [CMD_W-1:0]       cmd_ff;
   logic [INDEX_W-1:0]     idx_ff;
   logic [VALUE_WIDTH-1:0] val_ff;
   logic [COUNT_W-1:0]     count_ff;
   logic                   sorted_ff;
   logic [CNT_W-1:0]       hs_ff;
   logic [CNT_W-1:0]       bp_ff;
   logic [ADDR_W-1:0]      pos_ff;
   logic [VALUE_WIDTH-1:0] cur_ff;
   logic                   rsp_valid_ff;
   logic [OUT_VALUE_W-1:0] rsp_data_ff;
   logic                   rsp_sorted_ff;

   logic                   accept;
   logic                   hold;
   logic                   resp_op;
   logic                   idx_ok;
   logic [CNT_W-1:0]       n_elem;
   logic [IDX_W-1:0]       left;
   logic [IDX_W-1:0]       right;
   logic                   l_ok;
   logic                   r_ok;
   logic [VALUE_WIDTH-1:0] bv1;
   logic [IDX_W-1:0]       best_idx;
   logic [VALUE_WIDTH-1:0] best_val;
   logic                   move;

   hse_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .uword  (uword),
      .step   (step)
   );

   assign req_tready = (uword.op == OP_ACCEPT);
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_sorted_ff;

   assign resp_op = (uword.op == OP_RESP_RD) || (uword.op == OP_RESP_LD) ||
                    (uword.op == OP_RESP_SORT);
   assign hold    = resp_op && rsp_valid_ff && !rsp_tready;

   assign idx_ok = 32'(idx_ff) < DEPTH;
   assign n_elem = (32'(count_ff) > DEPTH) ? CNT_W'(DEPTH) : CNT_W'(count_ff);

   // children of the hole; one spare bit keeps 2*pos+2 from wrapping
   assign left  = {1'b0, pos_ff, 1'b1};
   assign right = left + IDX_W'(1);

   always_comb begin
      l_ok     = (32'(left) < 32'(hs_ff)) && (rd_a_ff > cur_ff);
      bv1      = l_ok ? rd_a_ff : cur_ff;
      r_ok     = (32'(right) < 32'(hs_ff)) && (rd_b_ff > bv1);
      move     = l_ok || r_ok;
      best_idx = r_ok ? right : left;
      best_val = r_ok ? rd_b_ff : rd_a_ff;
   end

   always_comb begin
      status.item      = accept;
      status.cmd_sort  = (cmd_ff == CMD_SORT);
      status.cmd_load  = (cmd_ff == CMD_LOAD);
      status.bp_zero   = (bp_ff == '0);
      status.hs_le1    = (hs_ff <= CNT_W'(1));
      status.sift_move = move;
      status.hold      = hold;
   end

   // store port addresses and write port
   always_comb begin
      ra_a = ADDR_W'(idx_ff);
      ra_b = ADDR_W'(right);
      we   = 1'b0;
      wa   = pos_ff;
      wd   = cur_ff;
      unique case (uword.op)
         OP_RD_IDX: ra_a = ADDR_W'(idx_ff);
         OP_BUILD:  ra_a = ADDR_W'(bp_ff - CNT_W'(1));
         OP_SIFT_RD: begin
            ra_a = ADDR_W'(left);
            ra_b = ADDR_W'(right);
         end
         OP_EXTRACT: begin
            ra_a = '0;
            ra_b = ADDR_W'(hs_ff - CNT_W'(1));
         end
         OP_RESP_LD: begin
            we = idx_ok && !hold;
            wa = ADDR_W'(idx_ff);
            wd = val_ff;
         end
         OP_SIFT_CMP: begin
            // hole method: the sifted value lands only where it stops
            we = 1'b1;
            wa = pos_ff;
            wd = move ? best_val : cur_ff;
         end
         OP_EXT_SWAP: begin
            we = 1'b1;
            wa = ADDR_W'(hs_ff - CNT_W'(1));
            wd = rd_a_ff;
         end
         default: begin
            we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      rd_a_ff <= mem[ra_a];
      rd_b_ff <= mem[ra_b];
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_tuser;
         idx_ff <= req_tdata[INDEX_W-1:0];
         val_ff <= VALUE_WIDTH'(req_tdata[REQ_DATA_W-1:INDEX_W]);
      end
      unique case (uword.op)
         OP_SORT_INIT: begin
            hs_ff <= n_elem;
            bp_ff <= n_elem >> 1;
         end
         OP_BUILD: begin
            if (bp_ff != '0) begin
               bp_ff  <= bp_ff - CNT_W'(1);
               pos_ff <= ADDR_W'(bp_ff - CNT_W'(1));
            end
         end
         OP_LOAD_CUR: cur_ff <= rd_a_ff;
         OP_SIFT_CMP: begin
            if (move) begin
               pos_ff <= ADDR_W'(best_idx);
            end
         end
         OP_EXT_SWAP: begin
            cur_ff <= rd_b_ff;
            hs_ff  <= hs_ff - CNT_W'(1);
            pos_ff <= '0;
         end
         default: begin
         end
      endcase
      if (reset) begin
         hs_ff  <= '0;
         bp_ff  <= '0;
         pos_ff <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= COUNT_W'(1);
         sorted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            count_ff <= csr_data;
         end
         if (resp_op && !hold) begin
            rsp_valid_ff <= 1'b1;
            unique case (uword.op)
               OP_RESP_RD: begin
                  rsp_data_ff   <= (cmd_ff == CMD_READ && idx_ok) ?
                                   OUT_VALUE_W'(rd_a_ff) : '0;
                  rsp_sorted_ff <= sorted_ff;
               end
               OP_RESP_LD: begin
                  rsp_data_ff   <= '0;
                  rsp_sorted_ff <= idx_ok ? 1'b0 : sorted_ff;
                  if (idx_ok) begin
                     sorted_ff <= 1'b0;
                  end
               end
               default: begin
                  rsp_data_ff   <= '0;
                  rsp_sorted_ff <= 1'b1;
                  sorted_ff     <= 1'b1;
               end
            endcase
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   `HSE_ASSERT_IMP(a_busy_no_accept, step != ST_IDLE, !req_tready)
   `HSE_ASSERT_IMP(a_sift_in_heap, step == ST_SIFT_CMP, 32'(pos_ff) < 32'(hs_ff))
   `HSE_ASSERT_IMP(a_sorted_from_done, $rose(sorted_ff), $past(step) == ST_DONE)
   `HSE_ASSERT_NXT(a_result_held, rsp_valid_ff && !rsp_tready,
                   $stable(rsp_data_ff) && $stable(rsp_sorted_ff))

endmodule

// File: src/hse_seq.sv
// Microcode sequencer: control ROM, step counter and conditional jumps.
module hse_seq (
   input  logic                      clock,
   input  logic                      reset,
   input  hse_pkg::status_type       status,
   output hse_pkg::ucode_type        uword,
   output logic [hse_pkg::STEP_W-1:0] step
);
   import hse_pkg::*;

   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;
   logic              take;

   function automatic ucode_type rom(input logic [STEP_W-1:0] s);
      ucode_type w;
      unique case (s)
         ST_IDLE:      w = '{OP_ACCEPT,    C_NO_ITEM,    ST_IDLE};
         ST_DISPATCH:  w = '{OP_NOP,       C_CMD_SORT,   ST_SORT_INIT};
         ST_RD_IDX:    w = '{OP_RD_IDX,    C_CMD_LOAD,   ST_RESP_LD};
         ST_RESP_RD:   w = '{OP_RESP_RD,   C_ALWAYS,     ST_IDLE};
         ST_RESP_LD:   w = '{OP_RESP_LD,   C_ALWAYS,     ST_IDLE};
         ST_SORT_INIT: w = '{OP_SORT_INIT, C_ALWAYS,     ST_BUILD};
         ST_BUILD:     w = '{OP_BUILD,     C_BP_ZERO,    ST_EXTRACT};
         ST_LOAD_CUR:  w = '{OP_LOAD_CUR,  C_NEVER,      ST_IDLE};
         ST_SIFT_RD:   w = '{OP_SIFT_RD,   C_NEVER,      ST_IDLE};
         // stay in the sift loop while an element moves down
         ST_SIFT_CMP:  w = '{OP_SIFT_CMP,  C_NEVER,      ST_IDLE};
         ST_SIFT_END:  w = '{OP_NOP,       C_BP_NONZERO, ST_BUILD};
         ST_EXTRACT:   w = '{OP_EXTRACT,   C_HS_LE1,     ST_DONE};
         ST_EXT_SWAP:  w = '{OP_EXT_SWAP,  C_ALWAYS,     ST_SIFT_RD};
         ST_DONE:      w = '{OP_RESP_SORT, C_ALWAYS,     ST_IDLE};
         default:      w = '{OP_NOP,       C_ALWAYS,     ST_IDLE};
      endcase
      return w;
   endfunction

   assign uword = rom(step_ff);
   assign step  = step_ff;

   always_comb begin
      unique case (uword.cond)
         C_NEVER:      take = 1'b0;
         C_ALWAYS:     take = 1'b1;
         C_NO_ITEM:    take = !status.item;
         C_CMD_SORT:   take = status.cmd_sort;
         C_CMD_LOAD:   take = status.cmd_load;
         C_BP_ZERO:    take = status.bp_zero;
         C_BP_NONZERO: take = !status.bp_zero;
         C_HS_LE1:     take = status.hs_le1;
         default:      take = 1'b0;
      endcase
   end

   always_comb begin
      priority if (status.hold) begin
         step_in = step_ff;
      end else if (uword.op == OP_SIFT_CMP) begin
         step_in = status.sift_move ? ST_SIFT_RD : ST_SIFT_END;
      end else if (take) begin
         step_in = uword.target;
      end else begin
         step_in = step_ff + STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ST_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule
